>>> sv/cdf_pkg.sv
// Shared widths and request types for the critically damped follower.
`timescale 1ns / 1ps

package cdf_pkg;

    localparam int WORD_W = 32;
    localparam int DT_W   = 24;

    // Request to the shared multiplier: one rounded, saturated fixed-point product
    typedef struct packed {
        logic                     go;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } mul_req_t;

    // Request to the shared divider: numerator is 2^(2F+1) or 2^(2F)
    typedef struct packed {
        logic              go;
        logic              twice_num;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

endpackage

>>> sv/critically_damped_follower.sv
// Critically damped follower: sequencer around a shared multiplier and divider.
`timescale 1ns / 1ps
// Work: an accepted word runs two serial divisions of 2*FRAC_BITS + 2 steps and ten
//   products, three of them under the second division, before its result is registered.
// Flow: one word in work, the next enters the cycle after its result is committed;
//   preset word or zero time step: S_DONE straight after acceptance, then the result register.
// Reset (aresetn low, synchronous): value and velocity cleared, smooth_time back to 0.25 s.

module critically_damped_follower
    import cdf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [WORD_W-1:0]        cfg_wr_data,
    // input words
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [WORD_W-1:0] s_target_value,
    input  logic [DT_W-1:0]          s_time_step,
    input  logic                     s_preset_to_target,
    // result words
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_new_value,
    output logic signed [WORD_W-1:0] m_new_velocity,
    output logic                     m_snapped
);

    // Fixed-point constants follow the fraction width
    localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(64'(1) << FRAC_BITS);
    localparam logic signed [WORD_W-1:0] K048  =
        WORD_W'(((64'(48) << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [WORD_W-1:0] K0235 =
        WORD_W'(((64'(235) << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam longint ST_MIN_RAW = ((64'(1) << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [WORD_W-1:0] ST_MIN = (ST_MIN_RAW < 1) ? WORD_W'(1) : WORD_W'(ST_MIN_RAW);
    localparam logic [WORD_W-1:0] ST_RESET = 32'd16384;
    localparam logic signed [WORD_W-1:0] S_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] S_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_OMEGA_GO   = 8'b0000_0010,
        S_OMEGA_WAIT = 8'b0000_0100,
        S_MUL        = 8'b0000_1000,
        S_MUL_WAIT   = 8'b0001_0000,
        S_DECAY_GO   = 8'b0010_0000,
        S_DECAY_WAIT = 8'b0100_0000,
        S_DONE       = 8'b1000_0000
    } state_t;

    // Product steps, in issue order
    typedef enum logic [3:0] {
        OP_X  = 4'd0,   // x = omega * dt
        OP_X2 = 4'd1,   // x^2
        OP_X3 = 4'd2,   // x^3
        OP_T1 = 4'd3,   // 0.48 x^2, folded into den
        OP_T2 = 4'd4,   // 0.235 x^3, folded into den
        OP_A1 = 4'd5,   // omega * disp, folded into velocity
        OP_VS = 4'd6,   // step = (vel + omega * disp) * dt
        OP_A2 = 4'd7,   // omega * step, taken off velocity
        OP_NV = 4'd8,   // new velocity = (...) * decay
        OP_RS = 4'd9    // value offset = (disp + step) * decay
    } op_t;

    function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? S_MIN : S_MAX;
        end
        return $signed(s[WORD_W-1:0]);
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? S_MIN : S_MAX;
        end
        return $signed(s[WORD_W-1:0]);
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [WORD_W-1:0]        smooth_time_reg;
    logic signed [WORD_W-1:0] cur_val_reg;
    logic signed [WORD_W-1:0] cur_vel_reg;

    // working registers for one word
    logic signed [WORD_W-1:0] tgt_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [WORD_W-1:0] disp_reg;
    logic signed [WORD_W-1:0] omega_reg;
    logic signed [WORD_W-1:0] x_reg;
    logic signed [WORD_W-1:0] x2_reg;
    logic signed [WORD_W-1:0] x3_reg;
    logic signed [WORD_W-1:0] den_reg;
    logic signed [WORD_W-1:0] decay_reg;
    logic signed [WORD_W-1:0] acc_reg;
    logic signed [WORD_W-1:0] vstep_reg;
    logic signed [WORD_W-1:0] nvel_reg;
    logic signed [WORD_W-1:0] res_reg;
    logic                     run_reg;

    // result register
    logic                     m_valid_reg;
    logic signed [WORD_W-1:0] m_value_reg;
    logic signed [WORD_W-1:0] m_velocity_reg;
    logic                     m_snapped_reg;

    mul_req_t                 mul_req;
    logic                     mul_done;
    logic signed [WORD_W-1:0] mul_result;
    div_req_t                 div_req;
    logic                     div_busy;
    logic [WORD_W-1:0]        div_quot;

    logic                     accept;
    logic                     commit;
    logic signed [WORD_W-1:0] dt_ext;
    logic signed [WORD_W-1:0] den_t2;
    logic                     snap;

    cdf_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .result  (mul_result)
    );

    cdf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    // hand the word over once the result register is free or being emptied
    assign commit  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign dt_ext  = $signed({{(WORD_W-DT_W){1'b0}}, dt_reg});

    // Overshoot guard: value has gone past the target on the far side
    assign snap = run_reg &&
                  (((tgt_reg > cur_val_reg) && (res_reg > tgt_reg)) ||
                   ((tgt_reg < cur_val_reg) && (res_reg < tgt_reg)));

    // Last denominator term, with the floor of one raw step
    always_comb begin
        den_t2 = sat_add(den_reg, mul_result);
        if (den_t2 < $signed(WORD_W'(1))) begin
            den_t2 = $signed(WORD_W'(1));
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        mul_req.go = (state_reg == S_MUL);
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (op_reg)
            OP_X:  begin mul_req.a = omega_reg; mul_req.b = dt_ext;    end
            OP_X2: begin mul_req.a = x_reg;     mul_req.b = x_reg;     end
            OP_X3: begin mul_req.a = x2_reg;    mul_req.b = x_reg;     end
            OP_T1: begin mul_req.a = K048;      mul_req.b = x2_reg;    end
            OP_T2: begin mul_req.a = K0235;     mul_req.b = x3_reg;    end
            OP_A1: begin mul_req.a = omega_reg; mul_req.b = disp_reg;  end
            OP_VS: begin mul_req.a = acc_reg;   mul_req.b = dt_ext;    end
            OP_A2: begin mul_req.a = omega_reg; mul_req.b = vstep_reg; end
            OP_NV: begin mul_req.a = acc_reg;   mul_req.b = decay_reg; end
            OP_RS: begin
                mul_req.a = sat_add(disp_reg, vstep_reg);
                mul_req.b = decay_reg;
            end
            default: begin mul_req.a = '0; mul_req.b = '0; end
        endcase
    end

    // Divider requests: omega from the clamped smoothing time, decay from den
    always_comb begin
        div_req.go        = (state_reg == S_OMEGA_GO) || (state_reg == S_DECAY_GO);
        div_req.twice_num = (state_reg == S_OMEGA_GO);
        if (state_reg == S_OMEGA_GO) begin
            div_req.divisor = (smooth_time_reg < ST_MIN) ? ST_MIN : smooth_time_reg;
        end else begin
            div_req.divisor = den_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_preset_to_target || (s_time_step == '0)) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_OMEGA_GO;
                    end
                end
            end
            S_OMEGA_GO: begin
                state_next = S_OMEGA_WAIT;
            end
            S_OMEGA_WAIT: begin
                if (!div_busy) begin
                    op_next    = OP_X;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                state_next = S_MUL;
                case (op_reg)
                    OP_X:    op_next = OP_X2;
                    OP_X2:   op_next = OP_X3;
                    OP_X3:   op_next = OP_T1;
                    OP_T1:   op_next = OP_T2;
                    OP_T2:   state_next = S_DECAY_GO;
                    OP_A1:   op_next = OP_VS;
                    OP_VS:   op_next = OP_A2;
                    OP_A2:   state_next = S_DECAY_WAIT;
                    OP_NV:   op_next = OP_RS;
                    OP_RS:   state_next = S_DONE;
                    default: state_next = S_DONE;
                endcase
            end
            S_DECAY_GO: begin
                // velocity products do not need decay: run them under the division
                op_next    = OP_A1;
                state_next = S_MUL;
            end
            S_DECAY_WAIT: begin
                if (!div_busy) begin
                    op_next    = OP_NV;
                    state_next = S_MUL;
                end
            end
            S_DONE: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_X;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // Configuration and follower state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_time_reg <= ST_RESET;
            cur_val_reg     <= '0;
            cur_vel_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                smooth_time_reg <= cfg_wr_data;
            end
            if (commit) begin
                cur_val_reg <= snap ? tgt_reg : res_reg;
                cur_vel_reg <= snap ? '0 : nvel_reg;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            tgt_reg  <= s_target_value;
            dt_reg   <= s_time_step;
            disp_reg <= sat_sub(cur_val_reg, s_target_value);
            run_reg  <= !s_preset_to_target && (s_time_step != '0);
            if (s_preset_to_target) begin
                // preset: jump onto the target, drop the velocity
                res_reg  <= s_target_value;
                nvel_reg <= '0;
            end else begin
                // hold the state; a zero step simply repeats it
                res_reg  <= cur_val_reg;
                nvel_reg <= cur_vel_reg;
            end
        end
        if ((state_reg == S_OMEGA_WAIT) && !div_busy) begin
            omega_reg <= $signed(div_quot);
        end
        if ((state_reg == S_DECAY_WAIT) && !div_busy) begin
            decay_reg <= $signed(div_quot);
        end
        if ((state_reg == S_MUL_WAIT) && mul_done) begin
            case (op_reg)
                OP_X:    x_reg     <= mul_result;
                OP_X2:   x2_reg    <= mul_result;
                OP_X3:   x3_reg    <= mul_result;
                OP_T1:   den_reg   <= sat_add(sat_add(ONE_Q, x_reg), mul_result);
                OP_T2:   den_reg   <= den_t2;
                OP_A1:   acc_reg   <= sat_add(cur_vel_reg, mul_result);
                OP_VS:   vstep_reg <= mul_result;
                OP_A2:   acc_reg   <= sat_sub(cur_vel_reg, mul_result);
                OP_NV:   nvel_reg  <= mul_result;
                OP_RS:   res_reg   <= sat_add(tgt_reg, mul_result);
                default: res_reg   <= res_reg;
            endcase
        end
    end

    // Result register: load on commit, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_value_reg    <= snap ? tgt_reg : res_reg;
            m_velocity_reg <= snap ? '0 : nvel_reg;
            m_snapped_reg  <= snap;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_new_value    = m_value_reg;
    assign m_new_velocity = m_velocity_reg;
    assign m_snapped      = m_snapped_reg;

`ifndef SYNTHESIS
    // The divider is never restarted while a division is under way
    a_div_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.go |-> !div_busy)
        else $error("divider started while busy");

    // A snapped result always carries zero velocity
    a_snap_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_snapped) |-> (m_new_velocity == '0))
        else $error("snapped result with nonzero velocity");

    // Decay factor lies in [0, 1.0] when it is used
    a_decay_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_MUL) && (op_reg == OP_NV)) |->
            ((decay_reg >= $signed(WORD_W'(0))) && (decay_reg <= ONE_Q)))
        else $error("decay factor out of range");

    // An accepted word closes the input until its result is handed over
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input reopened during work");
`endif

endmodule

>>> sv/cdf_qmul.sv
// Shared fixed-point multiplier: registered product, then rounding and saturation.
`timescale 1ns / 1ps

module cdf_qmul
    import cdf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mul_req_t                 req,
    output logic                     done,
    output logic signed [WORD_W-1:0] result
);

    localparam logic [2*WORD_W-1:0] HALF = (2*WORD_W)'(1) << (FRAC_BITS - 1);

    logic [WORD_W-1:0]   mag_a;
    logic [WORD_W-1:0]   mag_b;
    logic [2*WORD_W-1:0] prod_reg;
    logic                neg_reg;
    logic                vld_reg;
    logic [2*WORD_W-1:0] rounded;
    logic                big;

    assign mag_a = req.a[WORD_W-1] ? WORD_W'(-req.a) : WORD_W'(req.a);
    assign mag_b = req.b[WORD_W-1] ? WORD_W'(-req.b) : WORD_W'(req.b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= req.go;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.go) begin
            prod_reg <= {{WORD_W{1'b0}}, mag_a} * {{WORD_W{1'b0}}, mag_b};
            neg_reg  <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
        end
    end

    // round to nearest on the magnitude, ties away from zero
    assign rounded = (prod_reg + HALF) >> FRAC_BITS;
    assign big     = |rounded[2*WORD_W-1:WORD_W-1];

    always_comb begin
        if (neg_reg) begin
            result = big ? {1'b1, {(WORD_W-1){1'b0}}} : -$signed(rounded[WORD_W-1:0]);
        end else begin
            result = big ? {1'b0, {(WORD_W-1){1'b1}}} : $signed(rounded[WORD_W-1:0]);
        end
    end

    assign done = vld_reg;

endmodule

>>> sv/cdf_div.sv
// Shared restoring divider, one quotient bit a cycle, quotient saturated to 31 bits.
`timescale 1ns / 1ps

module cdf_div
    import cdf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    output logic              busy,
    output logic [WORD_W-1:0] quot
);

    localparam int DW = 2 * FRAC_BITS + 2;
    localparam int CW = $clog2(DW + 1);
    localparam int EW = (DW > WORD_W) ? DW : WORD_W;

    logic [DW-1:0]     dvd_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dsr_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic [WORD_W:0]   trial;
    logic              fits;
    logic [WORD_W:0]   rem_next;
    logic [EW-1:0]     q_ext;

    assign trial    = {rem_reg, dvd_reg[DW-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign rem_next = fits ? (trial - {1'b0, dsr_reg}) : trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.go) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CW'(1);
            busy_reg <= (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (req.go) begin
            dvd_reg <= req.twice_num ? (DW'(1) << (2 * FRAC_BITS + 1))
                                     : (DW'(1) << (2 * FRAC_BITS));
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DW-2:0], fits};
            rem_reg <= rem_next[WORD_W-1:0];
        end
    end

    assign q_ext = EW'(dvd_reg);
    assign quot  = (|q_ext[EW-1:WORD_W-1]) ? {1'b0, {(WORD_W-1){1'b1}}} : q_ext[WORD_W-1:0];
    assign busy  = busy_reg;

endmodule
